[sv/median_and_mad_unit_defines.svh]
// Assertion macros for the median/MAD unit.
`ifndef MEDIAN_AND_MAD_UNIT_DEFINES_SVH
`define MEDIAN_AND_MAD_UNIT_DEFINES_SVH

// Check a property every cycle outside reset.
`define MAM_ASSERT(name, expr, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Check that a trigger in one cycle leads to a condition in the next.
`define MAM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/mam_pkg.sv]
`default_nettype none
package mam_pkg;
    localparam int DEF_MAX_SAMPLES = 1024;
    localparam int DEF_VALUE_BITS  = 16;
    localparam int FIELD_BITS      = 16;
    localparam int COUNT_BITS      = 11;
    localparam int OUT_TDATA_BITS  = 48;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_MED,
        ST_MAD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic shift;
        logic load;
    } t_chain_ctl;
endpackage
`default_nettype wire

[sv/mam_cell.sv]
`default_nettype none
module mam_cell #(
    parameter int VALUE_BITS = mam_pkg::DEF_VALUE_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_shift,
    input  wire logic [VALUE_BITS-1:0] i_d,
    output logic      [VALUE_BITS-1:0] o_q
);
    logic [VALUE_BITS-1:0] r_q;

    // Take the neighbor's sample on every shift
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;
endmodule
`default_nettype wire

[sv/mam_ctrl.sv]
`default_nettype none
module mam_ctrl #(
    parameter int MAX_SAMPLES = mam_pkg::DEF_MAX_SAMPLES,
    parameter int VALUE_BITS  = mam_pkg::DEF_VALUE_BITS,
    parameter int CW          = $clog2(MAX_SAMPLES + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    input  wire logic                  i_s_tlast,
    output logic                       o_s_tready,
    input  wire logic [VALUE_BITS-1:0] i_tail,
    output mam_pkg::t_chain_ctl        o_ctl,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic      [VALUE_BITS-1:0] o_median,
    output logic      [VALUE_BITS-1:0] o_mad,
    output logic      [CW-1:0]         o_count,
    output logic                       o_overflow
);
    import mam_pkg::*;

    localparam int PW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int BW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam logic [CW-1:0] MAXC     = CW'(MAX_SAMPLES);
    localparam logic [PW-1:0] POS_LAST = PW'(MAX_SAMPLES - 1);
    localparam logic [BW-1:0] BIT_TOP  = BW'(VALUE_BITS - 1);

    t_state                r_state, n_state;
    logic [CW-1:0]         r_n, n_n;
    logic                  r_drop, n_drop;
    logic [PW-1:0]         r_pos, n_pos;
    logic [BW-1:0]         r_bit, n_bit;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [CW-1:0]         r_k, n_k;
    logic [VALUE_BITS-1:0] r_prefix, n_prefix;
    logic [VALUE_BITS-1:0] r_med, n_med;
    logic [VALUE_BITS-1:0] r_mad, n_mad;
    logic                  r_ov, n_ov;
    logic [VALUE_BITS-1:0] r_o_med, r_o_mad;
    logic [CW-1:0]         r_o_cnt;
    logic                  r_o_ovf;
    logic                  w_out_load;

    logic [VALUE_BITS-1:0] w_key, w_himask;
    logic                  w_hit;
    logic [CW-1:0]         w_c, w_n_inc;

    // Key of the element leaving the ring tail: sample or its deviation
    always_comb begin
        if (r_state == ST_MAD) begin
            w_key = (i_tail >= r_med) ? (i_tail - r_med) : (r_med - i_tail);
        end else begin
            w_key = i_tail;
        end
        for (int i = 0; i < VALUE_BITS; i++) begin
            w_himask[i] = (i > int'(r_bit));
        end
    end

    // Count kept elements matching the prefix with a zero at the current bit
    assign w_hit = (CW'(r_pos) >= (MAXC - r_n))
                && (((w_key ^ r_prefix) & w_himask) == '0)
                && !w_key[r_bit];
    assign w_c     = r_cnt + CW'(w_hit);
    assign w_n_inc = r_n + CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_n     <= '0;
            r_drop  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_drop  <= n_drop;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_bit    <= n_bit;
        r_cnt    <= n_cnt;
        r_k      <= n_k;
        r_prefix <= n_prefix;
        r_med    <= n_med;
        r_mad    <= n_mad;
        if (w_out_load) begin
            r_o_med <= r_med;
            r_o_mad <= r_mad;
            r_o_cnt <= r_n;
            r_o_ovf <= r_drop;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_n        = r_n;
        n_drop     = r_drop;
        n_pos      = r_pos;
        n_bit      = r_bit;
        n_cnt      = r_cnt;
        n_k        = r_k;
        n_prefix   = r_prefix;
        n_med      = r_med;
        n_mad      = r_mad;
        n_ov       = r_ov && !i_m_tready;
        w_out_load = 1'b0;
        o_ctl      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    // Store the sample or drop it when full
                    if (r_n < MAXC) begin
                        o_ctl.shift = 1'b1;
                        o_ctl.load  = 1'b1;
                        n_n         = w_n_inc;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_s_tlast) begin
                        n_state  = ST_MED;
                        n_k      = ((r_n < MAXC) ? w_n_inc : r_n) >> 1;
                        n_pos    = '0;
                        n_bit    = BIT_TOP;
                        n_cnt    = '0;
                        n_prefix = '0;
                    end
                end
            end
            ST_MED, ST_MAD: begin
                // Rotate the ring one place per cycle
                o_ctl.shift = 1'b1;
                n_pos       = r_pos + PW'(1);
                n_cnt       = w_c;
                if (r_pos == POS_LAST) begin
                    n_pos = '0;
                    n_cnt = '0;
                    if (r_k >= w_c) begin
                        n_prefix[r_bit] = 1'b1;
                        n_k             = r_k - w_c;
                    end
                    n_bit = r_bit - BW'(1);
                    if (r_bit == '0) begin
                        if (r_state == ST_MED) begin
                            n_med    = n_prefix;
                            n_state  = ST_MAD;
                            n_k      = r_n >> 1;
                            n_bit    = BIT_TOP;
                            n_prefix = '0;
                        end else begin
                            n_mad   = n_prefix;
                            n_state = ST_OUT;
                        end
                    end
                end
            end
            ST_OUT: begin
                // Hand over once the result register is free
                if (!r_ov || i_m_tready) begin
                    w_out_load = 1'b1;
                    n_ov       = 1'b1;
                    n_n        = '0;
                    n_drop     = 1'b0;
                    n_state    = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    assign o_m_tvalid = r_ov;
    assign o_median   = r_o_med;
    assign o_mad      = r_o_mad;
    assign o_count    = r_o_cnt;
    assign o_overflow = r_o_ovf;
endmodule
`default_nettype wire

[sv/median_and_mad_unit.sv]
// Samples are taken one per cycle while intake is open; a sample arriving while full is dropped.
// After the last sample the ring of cells rotates once per key bit, one
// element per cycle, first for the median and then again for the MAD;
// the result then goes to the output register once that register is free.
// The result is held there until taken; the next set may be loaded while it waits.
// Synchronous active-low reset clears control and count; the cells are not cleared.
`default_nettype none
module median_and_mad_unit #(
    parameter int MAX_SAMPLES = mam_pkg::DEF_MAX_SAMPLES,
    parameter int VALUE_BITS  = mam_pkg::DEF_VALUE_BITS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_s_tvalid,
    output logic                                      o_s_tready,
    input  wire logic [mam_pkg::FIELD_BITS-1:0]       i_s_tdata,  // value
    input  wire logic                                 i_s_tlast,  // last
    output logic                                      o_m_tvalid,
    input  wire logic                                 i_m_tready,
    output logic      [mam_pkg::OUT_TDATA_BITS-1:0]   o_m_tdata   // median, mad, count, overflow
);
    import mam_pkg::*;

    localparam int CW = $clog2(MAX_SAMPLES + 1);

    logic [VALUE_BITS-1:0] w_val, w_med, w_mad;
    logic [VALUE_BITS-1:0] w_q [MAX_SAMPLES];
    logic [CW-1:0]         w_cnt;
    logic                  w_ovf;
    logic [FIELD_BITS-1:0] w_med_f, w_mad_f;
    logic [COUNT_BITS-1:0] w_cnt_f;
    t_chain_ctl            w_ctl;

    // Fit the fixed-width fields to the sample width
    genvar g;
    for (g = 0; g < VALUE_BITS; g++) begin : g_vin
        if (g < FIELD_BITS) begin : g_on
            assign w_val[g] = i_s_tdata[g];
        end else begin : g_off
            assign w_val[g] = 1'b0;
        end
    end
    for (g = 0; g < FIELD_BITS; g++) begin : g_vout
        if (g < VALUE_BITS) begin : g_on
            assign w_med_f[g] = w_med[g];
            assign w_mad_f[g] = w_mad[g];
        end else begin : g_off
            assign w_med_f[g] = 1'b0;
            assign w_mad_f[g] = 1'b0;
        end
    end
    for (g = 0; g < COUNT_BITS; g++) begin : g_cout
        if (g < CW) begin : g_on
            assign w_cnt_f[g] = w_cnt[g];
        end else begin : g_off
            assign w_cnt_f[g] = 1'b0;
        end
    end

    // Ring of sample cells: head takes a new sample or the tail
    for (g = 0; g < MAX_SAMPLES; g++) begin : g_cell
        if (g == 0) begin : g_head
            mam_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
                .i_clk  (i_clk),
                .i_shift(w_ctl.shift),
                .i_d    (w_ctl.load ? w_val : w_q[MAX_SAMPLES-1]),
                .o_q    (w_q[g])
            );
        end else begin : g_body
            mam_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
                .i_clk  (i_clk),
                .i_shift(w_ctl.shift),
                .i_d    (w_q[g-1]),
                .o_q    (w_q[g])
            );
        end
    end

    mam_ctrl #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .VALUE_BITS (VALUE_BITS),
        .CW         (CW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .i_s_tlast (i_s_tlast),
        .o_s_tready(o_s_tready),
        .i_tail    (w_q[MAX_SAMPLES-1]),
        .o_ctl     (w_ctl),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_median  (w_med),
        .o_mad     (w_mad),
        .o_count   (w_cnt),
        .o_overflow(w_ovf)
    );

    assign o_m_tdata = {4'b0, w_ovf, w_cnt_f, w_mad_f, w_med_f};
endmodule
`default_nettype wire

[sv/mam_checker.sv]
`default_nettype none
`include "median_and_mad_unit_defines.svh"
module mam_checker (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 i_s_tvalid,
    input wire logic                                 o_s_tready,
    input wire logic                                 i_s_tlast,
    input wire logic                                 o_m_tvalid,
    input wire logic                                 i_m_tready,
    input wire logic [mam_pkg::OUT_TDATA_BITS-1:0]   o_m_tdata
);
    logic w_in_req;
    assign w_in_req = i_s_tvalid && o_s_tready;

    // A stalled result stays offered
    `MAM_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid, "result dropped")
    // Every result covers at least one sample
    `MAM_ASSERT(a_count_nz, !o_m_tvalid || (o_m_tdata[42:32] != 11'd0), "zero count")
    // A closing request starts the selection and stops intake
    `MAM_ASSERT_NEXT(a_last_busy, w_in_req && i_s_tlast, !o_s_tready, "intake after last")
endmodule

bind median_and_mad_unit mam_checker u_mam_checker (.*);
`default_nettype wire

[verif/median_and_mad_unit_test.sv]
`default_nettype none
module median_and_mad_unit_test;
    import mam_pkg::*;

    localparam int MAX_N      = DEF_MAX_SAMPLES;
    localparam int HOLD_LEN   = 80000;
    localparam int IDLE_LIMIT = 300000;
    localparam int TAIL_WAIT  = 200;

    typedef struct {
        logic [FIELD_BITS-1:0] median;
        logic [FIELD_BITS-1:0] mad;
        logic [COUNT_BITS-1:0] count;
        logic                  overflow;
    } t_summary;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      s_valid;
    logic                      o_s_tready;
    logic [FIELD_BITS-1:0]     s_data;
    logic                      s_last;
    logic                      o_m_tvalid;
    logic                      m_ready;
    logic [OUT_TDATA_BITS-1:0] o_m_tdata;

    median_and_mad_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_data),      // value
        .i_s_tlast  (s_last),      // last
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata)    // median, mad, count, overflow
    );

    // Shadow of the set being collected
    logic [FIELD_BITS-1:0] set_store [MAX_N];
    int unsigned           set_count;
    logic                  set_dropped;
    t_summary              summary_q [$];

    int unsigned snd_idle_pct;
    int unsigned rcv_stall_pct;
    int unsigned hold_seq;
    int unsigned hold_seen;
    int unsigned hold_cnt;
    int unsigned idle_cycles;
    int unsigned errors;
    int unsigned items_sent;
    int unsigned sets_sent;
    int unsigned results_seen;
    int unsigned overflow_sets;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch %s: got %0d, expected %0d (result %0d)",
                 what, got, want, results_seen);
        errors++;
    endtask

    // Rank n/2 of a list, ascending
    function automatic int unsigned mid_rank(input int unsigned vals [$]);
        vals.sort();
        return vals[vals.size() / 2];
    endfunction

    // Fold one accepted sample into the shadow set; on last, queue the summary
    task automatic collect_sample(input logic [FIELD_BITS-1:0] v, input logic l);
        int unsigned vals [$];
        int unsigned devs [$];
        int unsigned med;
        t_summary    s;
        if (set_count < MAX_N) begin
            set_store[set_count] = v;
            set_count++;
        end else begin
            set_dropped = 1'b1;
        end
        if (l) begin
            for (int i = 0; i < set_count; i++) vals.insert(vals.size(), 32'(set_store[i]));
            med = mid_rank(vals);
            for (int i = 0; i < set_count; i++)
                devs.insert(devs.size(), (32'(set_store[i]) >= med) ? 32'(set_store[i]) - med
                                                                    : med - 32'(set_store[i]));
            s.median   = med[FIELD_BITS-1:0];
            s.mad      = FIELD_BITS'(mid_rank(devs));
            s.count    = set_count[COUNT_BITS-1:0];
            s.overflow = set_dropped;
            summary_q.insert(summary_q.size(), s);
            if (set_dropped) overflow_sets++;
            sets_sent++;
            set_count   = 0;
            set_dropped = 1'b0;
        end
    endtask

    // Offer one request and hold it until accepted
    task automatic send_sample(input logic [FIELD_BITS-1:0] v, input logic l);
        logic took;
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= v;
        s_last  <= l;
        do begin
            @(negedge i_clk);
            took = o_s_tready;
            @(posedge i_clk);
        end while (!took);
        items_sent++;
        collect_sample(v, l);
    endtask

    task automatic send_set(input int unsigned n);
        for (int i = 0; i < n; i++) send_sample(FIELD_BITS'($urandom_range(65535)), i == n - 1);
    endtask

    // Receiver: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_seen != hold_seq) begin
            hold_seen <= hold_seq;
            hold_cnt  <= HOLD_LEN;
            m_ready   <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // Check each accepted result against the oldest summary
    always @(negedge i_clk) begin
        t_summary want;
        if (i_rst_n && o_m_tvalid && m_ready) begin
            if (summary_q.size() == 0) begin
                $display("unexpected result 0x%012h", o_m_tdata);
                errors++;
            end else begin
                want = summary_q.pop_front();
                if (o_m_tdata[15:0] !== want.median)
                    report_mismatch("median", 32'(o_m_tdata[15:0]), 32'(want.median));
                if (o_m_tdata[31:16] !== want.mad)
                    report_mismatch("mad", 32'(o_m_tdata[31:16]), 32'(want.mad));
                if (o_m_tdata[42:32] !== want.count)
                    report_mismatch("count", 32'(o_m_tdata[42:32]), 32'(want.count));
                if (o_m_tdata[43] !== want.overflow)
                    report_mismatch("overflow", 32'(o_m_tdata[43]), 32'(want.overflow));
            end
            results_seen++;
        end
    end

    // Watchdog on cycles without any accepted request
    always @(negedge i_clk) begin
        if (!i_rst_n || (s_valid && o_s_tready) || (o_m_tvalid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no progress, %0d results pending", summary_q.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    task automatic test_directed();
        send_sample(16'd1234, 1'b1);                        // single sample
        send_sample(16'd10, 1'b0); send_sample(16'd20, 1'b1); // upper median
        send_sample(16'hFFFF, 1'b0); send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b1);                        // extremes
        for (int i = 0; i < 4; i++) send_sample(16'h0000, i == 3);
        for (int i = 0; i < 3; i++) send_sample(16'hFFFF, i == 2);
        send_sample(16'd7, 1'b0); send_sample(16'd3, 1'b0); send_sample(16'd9, 1'b0);
        send_sample(16'd3, 1'b0); send_sample(16'd100, 1'b1); // duplicates, outlier
        send_sample(16'h5555, 1'b0); send_sample(16'hAAAA, 1'b1);
    endtask

    task automatic test_random_sets(input int unsigned sets);
        for (int s = 0; s < sets; s++)
            send_set(($urandom_range(99) < 15) ? $urandom_range(1, 4)
                                               : $urandom_range(5, 48));
    endtask

    task automatic test_backpressure();
        hold_seq++;
        for (int s = 0; s < 4; s++) send_set($urandom_range(1, 6));
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        s_last  = 1'b0;
        m_ready = 1'b0;
        snd_idle_pct = 0; rcv_stall_pct = 0;
        hold_seq = 0; hold_seen = 0; hold_cnt = 0; idle_cycles = 0;
        errors = 0; items_sent = 0; sets_sent = 0; results_seen = 0; overflow_sets = 0;
        set_count = 0; set_dropped = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        snd_idle_pct = 0;  rcv_stall_pct = 0;  test_random_sets(7);
        snd_idle_pct = 85; rcv_stall_pct = 0;  test_random_sets(7);
        snd_idle_pct = 0;  rcv_stall_pct = 85; test_random_sets(7);
        snd_idle_pct = 29; rcv_stall_pct = 29; test_random_sets(7);
        snd_idle_pct = 0;  rcv_stall_pct = 0;  test_backpressure();
        s_valid <= 1'b0;

        // Drain, then let the tail settle
        while (summary_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        $display("covered %0d samples in %0d sets (%0d with dropped samples), %0d results",
                 items_sent, sets_sent, overflow_sets, results_seen);
        $display("idle phases: none, sender, receiver, both; one long receiver hold-off");
        if (errors == 0 && summary_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
`default_nettype wire
